[rtl/ngc_pkg.sv]
`default_nettype none
package ngc_pkg;

  localparam int unsigned MAX_DEGREE  = 256;
  localparam int unsigned BUF_AW      = 8;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned LABEL_W     = 16;
  localparam int unsigned VID_W       = 16;
  localparam int unsigned LIN_W       = 16;
  localparam int unsigned LOG_W       = 28;
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned LOG_ITERS   = 24;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [ACC_W-1:0] LOG_MAX = 32'h0FFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_A  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_B  = 2'd2;

  localparam logic REQ_LABEL    = 1'b0;
  localparam logic REQ_NEIGHBOR = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LABWR, OP_LABRD, OP_STORE, OP_SINIT, OP_RDI, OP_KEY, OP_CHK,
    OP_CMP, OP_GRD0, OP_GFIRST, OP_GNEXT, OP_GDIFF, OP_LOGIT, OP_M1, OP_M2, OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic last_flag;
    logic i_ge_n;
    logic j_zero;
    logic gt;
    logic k_ge_n;
    logic d_nz;
    logic it_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

[rtl/neighbor_gap_cost.sv]
`default_nettype none
// Scores one vertex's neighbour list under a vertex relabelling. A label
// transaction writes the label table; a neighbour transaction passes through
// a registered label-table read, then a buffer store. The neighbour
// transaction marked last starts an insertion sort over the neighbour buffer,
// followed by a gap walk that runs the squaring log unit and its two-part
// ln 2 multiply on each nonzero gap. A finished result waits in the output
// register while new label and neighbour transactions are taken; the next
// list end waits for it to leave.
module neighbor_gap_cost
  import ngc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic [VID_W-1:0]      vertex_id_i,
  input  wire logic [LABEL_W-1:0]    label_value_i,
  input  wire logic                  last_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LIN_W-1:0]           lin_gap_o,
  output logic [LOG_W-1:0]           log_gap_o,
  output logic [CNT_W-1:0]           neighbor_count_o,
  output logic                       overflow_o
);

  cmd_t    cmd;
  status_t status;

  ngc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ngc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .vertex_id_i      (vertex_id_i),
    .label_value_i    (label_value_i),
    .last_i           (last_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .lin_gap_o        (lin_gap_o),
    .log_gap_o        (log_gap_o),
    .neighbor_count_o (neighbor_count_o),
    .overflow_o       (overflow_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

  // an overflowing list keeps a full buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> neighbor_count_o == CNT_W'(MAX_DEGREE))
    else $error("overflow reported without a full buffer");

  // a list of at most one label has no gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && neighbor_count_o <= CNT_W'(1) |-> lin_gap_o == '0 && log_gap_o == '0)
    else $error("gap reported for a single-label list");

  // a pending result holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lin_gap_o) && $stable(log_gap_o))
    else $error("stalled result changed");

endmodule
`default_nettype wire

[rtl/ngc_ctrl.sv]
`default_nettype none
module ngc_ctrl
  import ngc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_req_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_LAB    = 15'b000000000000010,
    S_SINIT  = 15'b000000000000100,
    S_SORT   = 15'b000000000001000,
    S_KEY    = 15'b000000000010000,
    S_CHK    = 15'b000000000100000,
    S_CMP    = 15'b000000001000000,
    S_GRD0   = 15'b000000010000000,
    S_GFIRST = 15'b000000100000000,
    S_GNEXT  = 15'b000001000000000,
    S_GDIFF  = 15'b000010000000000,
    S_LOG    = 15'b000100000000000,
    S_M1     = 15'b001000000000000,
    S_M2     = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // sequence the load, the sort and the gap walk
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i == REQ_LABEL) begin
            cmd_o.op = OP_LABWR;
          end else begin
            cmd_o.op = OP_LABRD;
            state_d  = S_LAB;
          end
        end
      end
      S_LAB: begin
        cmd_o.op = OP_STORE;
        state_d  = status_i.last_flag ? S_SINIT : S_IDLE;
      end
      S_SINIT: begin
        cmd_o.op = OP_SINIT;
        state_d  = S_SORT;
      end
      S_SORT: begin
        if (status_i.i_ge_n) begin
          state_d = S_GRD0;
        end else begin
          cmd_o.op = OP_RDI;
          state_d  = S_KEY;
        end
      end
      S_KEY: begin
        cmd_o.op = OP_KEY;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = OP_CHK;
        state_d  = status_i.j_zero ? S_SORT : S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        state_d  = status_i.gt ? S_CHK : S_SORT;
      end
      S_GRD0: begin
        cmd_o.op = OP_GRD0;
        state_d  = S_GFIRST;
      end
      S_GFIRST: begin
        cmd_o.op = OP_GFIRST;
        state_d  = S_GNEXT;
      end
      S_GNEXT: begin
        if (status_i.k_ge_n) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_GNEXT;
          state_d  = S_GDIFF;
        end
      end
      S_GDIFF: begin
        cmd_o.op = OP_GDIFF;
        state_d  = status_i.d_nz ? S_LOG : S_GNEXT;
      end
      S_LOG: begin
        cmd_o.op = OP_LOGIT;
        if (status_i.it_done) state_d = S_M1;
      end
      S_M1: begin
        cmd_o.op = OP_M1;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.op = OP_M2;
        state_d  = S_GNEXT;
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

[rtl/ngc_dp.sv]
`default_nettype none
module ngc_dp
  import ngc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [VID_W-1:0]      vertex_id_i,
  input  wire logic [LABEL_W-1:0]    label_value_i,
  input  wire logic                  last_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [LIN_W-1:0]           lin_gap_o,
  output logic [LOG_W-1:0]           log_gap_o,
  output logic [CNT_W-1:0]           neighbor_count_o,
  output logic                       overflow_o,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o
);

  logic                 swap_en_q;
  logic [VID_W-1:0]     swap_a_q, swap_b_q;
  logic [LABEL_W-1:0]   lab_mem [2**VID_W];
  logic [LABEL_W-1:0]   lab_rd_q;
  logic [LABEL_W-1:0]   buf_mem [MAX_DEGREE];
  logic [LABEL_W-1:0]   brd_q;
  logic [CNT_W-1:0]     fill_q, i_q, j_q, k_q;
  logic                 ovf_q, last_q;
  logic [LABEL_W-1:0]   key_q, prev_q, min_q;
  logic [31:0]          x_q;
  logic [3:0]           e_q;
  logic [LOG_ITERS-1:0] frac_q;
  logic [4:0]           it_q;
  logic [47:0]          plo_q;
  logic [ACC_W-1:0]     acc_q;
  logic                 out_valid_q;
  logic [LIN_W-1:0]     lin_q;
  logic [LOG_W-1:0]     log_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 ovf_out_q;

  logic [VID_W-1:0]     map_vid;
  logic                 buf_we;
  logic [BUF_AW-1:0]    buf_wa, buf_ra;
  logic [LABEL_W-1:0]   buf_wd;
  logic                 buf_re;
  logic [LABEL_W-1:0]   diff;
  logic [3:0]           diff_msb;
  logic [63:0]          sq;
  logic [32:0]          sq_t;
  logic [27:0]          l2;
  logic [61:0]          prod;
  logic [21:0]          term;

  function automatic logic [3:0] msb_of(input logic [15:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (v[b]) r = 4'(b);
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_en_q <= 1'b0;
      swap_a_q  <= '0;
      swap_b_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SWAP_EN: swap_en_q <= cfg_data_i[0];
        CFG_SWAP_A:  swap_a_q  <= cfg_data_i[VID_W-1:0];
        CFG_SWAP_B:  swap_b_q  <= cfg_data_i[VID_W-1:0];
        default: ;
      endcase
    end
  end

  // exchange labels of the swap pair
  always_comb begin
    if (swap_en_q && vertex_id_i == swap_a_q)      map_vid = swap_b_q;
    else if (swap_en_q && vertex_id_i == swap_b_q) map_vid = swap_a_q;
    else                                           map_vid = vertex_id_i;
  end

  // label table
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LABWR) lab_mem[vertex_id_i] <= label_value_i;
    if (cmd_i.op == OP_LABRD) lab_rd_q <= lab_mem[map_vid];
  end

  // buffer port selection
  always_comb begin
    buf_we = 1'b0;
    buf_wa = j_q[BUF_AW-1:0];
    buf_wd = key_q;
    buf_re = 1'b0;
    buf_ra = i_q[BUF_AW-1:0];
    case (cmd_i.op)
      OP_STORE: begin
        buf_we = (fill_q < CNT_W'(MAX_DEGREE));
        buf_wa = fill_q[BUF_AW-1:0];
        buf_wd = lab_rd_q;
      end
      OP_RDI: buf_re = 1'b1;
      OP_CHK: begin
        if (j_q == '0) begin
          buf_we = 1'b1;
        end else begin
          buf_re = 1'b1;
          buf_ra = BUF_AW'(j_q - 1'b1);
        end
      end
      OP_CMP: begin
        buf_we = 1'b1;
        buf_wd = (brd_q > key_q) ? brd_q : key_q;
      end
      OP_GRD0: begin
        buf_re = 1'b1;
        buf_ra = '0;
      end
      OP_GNEXT: begin
        buf_re = 1'b1;
        buf_ra = k_q[BUF_AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    if (buf_re) brd_q <= buf_mem[buf_ra];
  end

  // log unit arithmetic
  assign diff     = brd_q - prev_q;
  assign diff_msb = msb_of(diff);
  assign sq       = 64'(x_q) * 64'(x_q);
  assign sq_t     = sq[63:31];
  assign l2       = {e_q, frac_q};
  assign prod     = ((62'(l2) * 62'(LN2_Q32[31:16])) << 16) + 62'(plo_q) + (62'd1 << 39);
  assign term     = prod[61:40];

  // list counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // raise the result on a list end, drop it once taken
      if (cmd_i.op == OP_OUT)               out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LABRD: last_q <= last_i;
        OP_STORE: begin
          if (fill_q < CNT_W'(MAX_DEGREE)) fill_q <= fill_q + 1'b1;
          else                             ovf_q  <= 1'b1;
        end
        OP_SINIT: i_q <= CNT_W'(1);
        OP_KEY:   j_q <= i_q;
        OP_CHK:   if (j_q == '0) i_q <= i_q + 1'b1;
        OP_CMP: begin
          if (brd_q > key_q) j_q <= j_q - 1'b1;
          else               i_q <= i_q + 1'b1;
        end
        OP_GFIRST: k_q <= CNT_W'(1);
        OP_GDIFF: begin
          k_q  <= k_q + 1'b1;
          it_q <= '0;
        end
        OP_LOGIT: it_q <= it_q + 1'b1;
        OP_OUT: begin
          fill_q <= '0;
          ovf_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // sort key, gap walk and log payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_KEY: key_q <= brd_q;
      OP_GFIRST: begin
        prev_q <= brd_q;
        min_q  <= brd_q;
        acc_q  <= '0;
      end
      OP_GDIFF: begin
        prev_q <= brd_q;
        e_q    <= diff_msb;
        x_q    <= 32'(diff) << (5'd31 - {1'b0, diff_msb});
        frac_q <= '0;
      end
      OP_LOGIT: begin
        if (sq_t[32]) begin
          x_q    <= sq_t[32:1];
          frac_q <= {frac_q[LOG_ITERS-2:0], 1'b1};
        end else begin
          x_q    <= sq_t[31:0];
          frac_q <= {frac_q[LOG_ITERS-2:0], 1'b0};
        end
      end
      OP_M1: plo_q <= 48'(l2) * 48'(LN2_Q32[15:0]);
      OP_M2: acc_q <= acc_q + ACC_W'(term);
      OP_OUT: begin
        lin_q     <= (fill_q > CNT_W'(1)) ? LIN_W'(prev_q - min_q) : '0;
        log_q     <= (acc_q > LOG_MAX) ? LOG_MAX[LOG_W-1:0] : acc_q[LOG_W-1:0];
        cnt_q     <= fill_q;
        ovf_out_q <= ovf_q;
      end
      default: ;
    endcase
  end

  assign status_o.last_flag = last_q;
  assign status_o.i_ge_n    = (i_q >= fill_q);
  assign status_o.j_zero    = (j_q == '0);
  assign status_o.gt        = (brd_q > key_q);
  assign status_o.k_ge_n    = (k_q >= fill_q);
  assign status_o.d_nz      = (diff != '0);
  assign status_o.it_done   = (it_q == 5'(LOG_ITERS - 1));
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign lin_gap_o        = lin_q;
  assign log_gap_o        = log_q;
  assign neighbor_count_o = cnt_q;
  assign overflow_o       = ovf_out_q;

endmodule
`default_nettype wire

[bench/neighbor_gap_cost_test.sv]
`timescale 1ns / 1ps

module neighbor_gap_cost_test;
  import ngc_pkg::*;

  typedef struct packed {
    logic [LIN_W-1:0] lin;
    logic [LOG_W-1:0] lg;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } score_t;

  typedef struct packed {
    logic             req;
    logic [VID_W-1:0] vid;
    logic [LABEL_W-1:0] val;
    logic             lst;
    bit               typed;
    score_t           score;
  } step_row_t;

  localparam int NUM_ROWS = 22;
  localparam int RANDOM_ITEMS = 1950;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SWAP_EN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  req_type_i = REQ_LABEL;
  logic [VID_W-1:0]      vertex_id_i = '0;
  logic [LABEL_W-1:0]    label_value_i = '0;
  logic                  last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LIN_W-1:0]      lin_gap_o;
  logic [LOG_W-1:0]      log_gap_o;
  logic [CNT_W-1:0]      neighbor_count_o;
  logic                  overflow_o;

  neighbor_gap_cost dut (.*);

  // predictor state
  logic [LABEL_W-1:0] label_shadow [2**VID_W];
  bit                 label_written [2**VID_W];
  logic [VID_W-1:0]   known_vertices [$];
  logic [LABEL_W-1:0] list_labels [$];
  bit                 list_cut;
  bit                 swap_en_q;
  logic [VID_W-1:0]   swap_a_q, swap_b_q;

  score_t pending_scores [$];
  int     mismatches = 0;
  int     items_sent = 0;
  int     scores_seen = 0;
  int     cut_lists = 0;
  int     burst_left = 0;

  step_row_t step_rows [NUM_ROWS] = '{
    '{REQ_LABEL,    16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_LABEL,    16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h0000, 16'h1234, 1'b1, 1'b1, '{16'd0, 28'd0, 9'd1, 1'b0}},
    '{REQ_NEIGHBOR, 16'hFFFF, 16'h0000, 1'b1, 1'b1, '{16'd0, 28'd0, 9'd1, 1'b0}},
    '{REQ_NEIGHBOR, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'hFFFF, 16'h0000, 1'b1, 1'b0, '0},
    '{REQ_LABEL,    16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
    '{REQ_LABEL,    16'hAAAA, 16'h5555, 1'b1, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h5555, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h5555, 16'hFFFF, 1'b1, 1'b1, '{16'd0, 28'd0, 9'd2, 1'b0}},
    '{REQ_NEIGHBOR, 16'hAAAA, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h5555, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{REQ_LABEL,    16'h0001, 16'h0001, 1'b0, 1'b0, '0},
    '{REQ_LABEL,    16'h0002, 16'h0002, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h0001, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h0002, 16'h0000, 1'b1, 1'b1, '{16'd1, 28'd0, 9'd2, 1'b0}},
    '{REQ_NEIGHBOR, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h0001, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'hFFFF, 16'h0000, 1'b0, 1'b0, '0},
    '{REQ_LABEL,    16'h0001, 16'h7FFF, 1'b0, 1'b0, '0},
    '{REQ_NEIGHBOR, 16'h0002, 16'h0000, 1'b1, 1'b0, '0}
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ln(d) in Q.16: integer exponent plus 24 squaring steps, then scale by ln 2
  function automatic logic [63:0] ln_q16(logic [31:0] d);
    int unsigned e;
    logic [63:0] x, frac, l2;
    e = 0;
    frac = '0;
    while (e < 31 && (d >> (e + 1)) != 0) e++;
    x = ({32'b0, d} << (31 - e)) & 64'hFFFF_FFFF;
    for (int i = 0; i < LOG_ITERS; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    l2 = (64'(e) << 24) | frac;
    return (l2 * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
  endfunction

  // score the buffered list once its last neighbour arrives
  function automatic score_t score_list();
    score_t s;
    logic [63:0] logsum, d;
    logsum = '0;
    list_labels.sort();
    s.lin = '0;
    if (list_labels.size() > 1)
      s.lin = list_labels[$] - list_labels[0];
    for (int i = 1; i < list_labels.size(); i++) begin
      d = 64'(list_labels[i]) - 64'(list_labels[i-1]);
      if (d != 0) logsum += ln_q16(d[31:0]);
    end
    s.lg = (logsum > 64'(LOG_MAX)) ? LOG_MAX[LOG_W-1:0] : logsum[LOG_W-1:0];
    s.cnt = CNT_W'(list_labels.size());
    s.ovf = list_cut;
    return s;
  endfunction

  // advance the predictor by one accepted transaction
  task automatic score_transaction(logic req, logic [VID_W-1:0] vid,
                                   logic [LABEL_W-1:0] val, logic lst,
                                   bit typed, score_t typed_score);
    logic [VID_W-1:0] src;
    score_t s;
    if (req == REQ_LABEL) begin
      label_shadow[vid] = val;
      if (!label_written[vid]) known_vertices.push_back(vid);
      label_written[vid] = 1'b1;
      return;
    end
    src = vid;
    if (swap_en_q && vid == swap_a_q) src = swap_b_q;
    else if (swap_en_q && vid == swap_b_q) src = swap_a_q;
    if (list_labels.size() < MAX_DEGREE) list_labels.push_back(label_shadow[src]);
    else list_cut = 1'b1;
    if (!lst) return;
    s = score_list();
    if (s.ovf) cut_lists++;
    pending_scores.push_back(typed ? typed_score : s);
    list_labels.delete();
    list_cut = 1'b0;
  endtask

  // drive one transaction from a falling edge and hold it until taken
  task automatic send(logic req, logic [VID_W-1:0] vid, logic [LABEL_W-1:0] val,
                      logic lst, bit typed = 1'b0, score_t typed_score = '0);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i = 1'b1;
    req_type_i = req;
    vertex_id_i = vid;
    label_value_i = val;
    last_i = lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    score_transaction(req, vid, val, lst, typed, typed_score);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_SWAP_EN) swap_en_q = data[0];
    else if (idx == CFG_SWAP_A) swap_a_q = data;
    else swap_b_q = data;
  endtask

  // let the block drain before touching the registers
  task automatic wait_idle();
    while (pending_scores.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [VID_W-1:0] pick_vertex();
    return known_vertices[$urandom_range(0, known_vertices.size() - 1)];
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
  endtask

  // receiver stalls in randomly chosen modes
  int stall_mode = 0;
  int stall_tick = 0;
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_tick[3];
    endcase
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scores_seen++;
      if (pending_scores.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected", $time);
      end else begin
        want = pending_scores.pop_front();
        if (lin_gap_o !== want.lin) report("lin_gap", lin_gap_o, want.lin);
        if (log_gap_o !== want.lg) report("log_gap", log_gap_o, want.lg);
        if (neighbor_count_o !== want.cnt)
          report("neighbor_count", neighbor_count_o, want.cnt);
        if (overflow_o !== want.ovf) report("overflow", overflow_o, want.ovf);
      end
    end
  end

  initial begin
    int phase, list_len;
    logic [VID_W-1:0] va, vb;
    swap_en_q = 1'b0;
    swap_a_q = '0;
    swap_b_q = '0;
    list_cut = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows
    for (int r = 0; r < NUM_ROWS; r++)
      send(step_rows[r].req, step_rows[r].vid, step_rows[r].val, step_rows[r].lst,
           step_rows[r].typed, step_rows[r].score);

    // random phases, each under its own swap setting
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      case (phase % 5)
        0: begin va = 16'h0000; vb = 16'hFFFF; end
        1: begin va = pick_vertex(); vb = va; end
        2: begin va = 16'hFFFF; vb = 16'h0000; end
        default: begin va = pick_vertex(); vb = pick_vertex(); end
      endcase
      write_reg(CFG_SWAP_A, va);
      write_reg(CFG_SWAP_B, vb);
      write_reg(CFG_SWAP_EN, (phase % 5 == 4) ? 16'h0000 : 16'h0001);

      // seed the table with fresh entries
      repeat ($urandom_range(10, 30))
        send(REQ_LABEL, 16'($urandom), 16'($urandom), 1'($urandom));

      for (int l = 0; l < 20; l++) begin
        if (phase == 2 && l == 0) list_len = MAX_DEGREE;
        else if (phase == 3 && l == 0) list_len = MAX_DEGREE + 3;
        else list_len = $urandom_range(1, 12);
        for (int k = 0; k < list_len; k++) begin
          // occasionally rewrite a known label in the middle of a list
          if ($urandom_range(0, 9) == 0)
            send(REQ_LABEL, pick_vertex(), 16'($urandom), 1'($urandom));
          case ($urandom_range(0, 5))
            0: send(REQ_NEIGHBOR, va, 16'($urandom), k == list_len - 1);
            1: send(REQ_NEIGHBOR, vb, 16'($urandom), k == list_len - 1);
            default: send(REQ_NEIGHBOR, pick_vertex(), 16'($urandom), k == list_len - 1);
          endcase
        end
      end
      phase++;
    end

    wait_idle();
    repeat (200) @(negedge clk_i);
    $display("Sent %0d transactions over %0d swap settings; %0d scores checked, %0d cut.",
             items_sent, phase, scores_seen, cut_lists);
    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
